// ===== design/ogf_pkg.sv =====
// shared types and constants for the occupancy grid log-odds fusion core
package ogf_pkg;

   localparam int MAP_WIDTH_DEF  = 512;
   localparam int MAP_HEIGHT_DEF = 512;
   localparam int LOCAL_SIZE_DEF = 512;
   localparam int QUEUE_DEPTH    = 4;

   localparam int COORD_W      = 12;
   localparam int GRID_FIELD_W = 9;
   localparam int FRAC_BITS    = 14;
   localparam int PROD_W       = 26;
   localparam int SUM_W        = 33;
   localparam int LO_W         = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_A    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_B    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_X  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_Y  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_INC  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISS_INC = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT    = 3'd6;

   localparam logic signed [15:0] ROT_A_RST    = 16'sd16384;
   localparam logic signed [15:0] ROT_B_RST    = 16'sd0;
   localparam logic signed [30:0] SHIFT_RST    = 31'sd0;
   localparam logic signed [15:0] HIT_INC_RST  = 16'sd562;
   localparam logic signed [15:0] MISS_INC_RST = -16'sd217;
   localparam logic [14:0]        LIMIT_RST    = 15'd25600;

   localparam logic signed [7:0] VAL_OCCUPIED = 8'sd100;
   localparam logic signed [7:0] VAL_FREE     = 8'sd0;

   localparam int FREE_MAX = -211;
   localparam int OCC_MIN  = 347;

   localparam logic [1:0] CELL_FREE     = 2'd0;
   localparam logic [1:0] CELL_OCCUPIED = 2'd1;
   localparam logic [1:0] CELL_UNKNOWN  = 2'd2;

   typedef struct packed {
      logic [8:0]        local_row;
      logic [8:0]        local_col;
      logic signed [7:0] cell_value;
   } req_type;

   typedef struct packed {
      logic                   written;
      logic [GRID_FIELD_W-1:0] grid_x;
      logic [GRID_FIELD_W-1:0] grid_y;
      logic [1:0]             cell_state;
      logic signed [LO_W-1:0] log_odds_now;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] rot_a;
      logic signed [15:0] rot_b;
      logic signed [30:0] shift_x;
      logic signed [30:0] shift_y;
      logic signed [15:0] hit_increment;
      logic signed [15:0] miss_increment;
      logic [14:0]        log_odds_limit;
   } cfg_type;

   // one classified cell waiting for the read-modify-write side
   typedef struct packed {
      logic               upd;
      logic               hit;
      logic [COORD_W-1:0] gx;
      logic [COORD_W-1:0] gy;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/occupancy_grid_logodds_fusion_core.sv =====
// stages: request and product registers, queue, result register (updates: ram read first)
// throughput: one skipped cell per cycle unless the output stalls; an updated cell is
//   read, then written, before the next cell is taken from the queue
// reset: registers take their reset values; the store is then zeroed one entry a cycle,
//   with req_stall high until done
module occupancy_grid_logodds_fusion_core #(
   parameter int MAP_WIDTH  = ogf_pkg::MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT = ogf_pkg::MAP_HEIGHT_DEF,
   parameter int LOCAL_SIZE = ogf_pkg::LOCAL_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ogf_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ogf_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ogf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ogf_pkg::CSR_DATA_W-1:0]     csr_data
);

   ogf_pkg::cfg_type          cfg_ff;
   ogf_pkg::queue_status_type q_status;
   ogf_pkg::entry_type        push_entry, head;
   logic                      push, pop, clearing;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_a          <= ogf_pkg::ROT_A_RST;
         cfg_ff.rot_b          <= ogf_pkg::ROT_B_RST;
         cfg_ff.shift_x        <= ogf_pkg::SHIFT_RST;
         cfg_ff.shift_y        <= ogf_pkg::SHIFT_RST;
         cfg_ff.hit_increment  <= ogf_pkg::HIT_INC_RST;
         cfg_ff.miss_increment <= ogf_pkg::MISS_INC_RST;
         cfg_ff.log_odds_limit <= ogf_pkg::LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ogf_pkg::CSR_ROT_A:    cfg_ff.rot_a          <= csr_data[15:0];
            ogf_pkg::CSR_ROT_B:    cfg_ff.rot_b          <= csr_data[15:0];
            ogf_pkg::CSR_SHIFT_X:  cfg_ff.shift_x        <= csr_data[30:0];
            ogf_pkg::CSR_SHIFT_Y:  cfg_ff.shift_y        <= csr_data[30:0];
            ogf_pkg::CSR_HIT_INC:  cfg_ff.hit_increment  <= csr_data[15:0];
            ogf_pkg::CSR_MISS_INC: cfg_ff.miss_increment <= csr_data[15:0];
            ogf_pkg::CSR_LIMIT:    cfg_ff.log_odds_limit <= csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   ogf_front #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT),
      .LOCAL_SIZE (LOCAL_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .hold        (clearing),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   ogf_queue #(
      .DEPTH (ogf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   ogf_back #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .head        (head),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // nothing can be queued while the store is being cleared
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing |-> q_status.empty)
      else $error("queue holds a request during clearing pass");

   // a skipped request carries an all-zero result
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.written) |-> (rsp_payload == '0))
      else $error("skipped result has nonzero fields");

   // updated log-odds stays within the saturation bound
   a_lo_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.written) |->
         (($signed(rsp_payload.log_odds_now) <= $signed({1'b0, cfg_ff.log_odds_limit})) &&
          ($signed(rsp_payload.log_odds_now) >= -$signed({1'b0, cfg_ff.log_odds_limit}))))
      else $error("log-odds outside saturation limit");

   // no pop from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

// ===== design/ogf_ram.sv =====
// generic single-write, single-read ram with registered read data
module ogf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ogf_queue.sv =====
// short fifo of classified cells between the front and back ends
module ogf_queue #(
   parameter int DEPTH = ogf_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ogf_pkg::entry_type        push_entry,
   input  logic                      pop,
   output ogf_pkg::entry_type        head,
   output ogf_pkg::queue_status_type status
);

   localparam int PW = $clog2(DEPTH);

   ogf_pkg::entry_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (PW+1)'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== design/ogf_front.sv =====
// front end: request intake, fixed-point transform and cell classification
module ogf_front #(
   parameter int MAP_WIDTH  = ogf_pkg::MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT = ogf_pkg::MAP_HEIGHT_DEF,
   parameter int LOCAL_SIZE = ogf_pkg::LOCAL_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ogf_pkg::cfg_type          cfg,
   input  logic                      hold,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ogf_pkg::req_type          req_payload,
   input  ogf_pkg::queue_status_type q_status,
   output logic                      push,
   output ogf_pkg::entry_type        push_entry
);

   localparam int PW = ogf_pkg::PROD_W;
   localparam int SW = ogf_pkg::SUM_W;

   // stage 1: captured request
   logic              s1_valid_ff;
   logic [8:0]        s1_row_ff;
   logic [8:0]        s1_col_ff;
   logic signed [7:0] s1_val_ff;

   // stage 2: registered products
   logic                 s2_valid_ff;
   logic signed [PW-1:0] prod_aj_ff, prod_bi_ff, prod_bj_ff, prod_ai_ff;
   logic                 s2_ok_ff;
   logic                 s2_hit_ff;

   logic                 adv1, adv2, req_accept;
   logic signed [15:0]   rot_a, rot_b;
   logic signed [30:0]   shift_x, shift_y;
   logic signed [9:0]    row_s, col_s;
   logic signed [PW-1:0] prod_aj_in, prod_bi_in, prod_bj_in, prod_ai_in;
   logic                 local_ok, val_ok;
   logic signed [SW-1:0] x_sum, y_sum, gx_full, gy_full;
   logic                 in_grid;

   assign adv2       = !s2_valid_ff || !q_status.full;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_stall  = !adv1 || hold;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_accept;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_row_ff <= req_payload.local_row;
         s1_col_ff <= req_payload.local_col;
         s1_val_ff <= req_payload.cell_value;
      end
      if (adv2) begin
         prod_aj_ff <= prod_aj_in;
         prod_bi_ff <= prod_bi_in;
         prod_bj_ff <= prod_bj_in;
         prod_ai_ff <= prod_ai_in;
         s2_ok_ff   <= local_ok && val_ok;
         s2_hit_ff  <= (s1_val_ff == ogf_pkg::VAL_OCCUPIED);
      end
   end

   assign rot_a   = cfg.rot_a;
   assign rot_b   = cfg.rot_b;
   assign shift_x = cfg.shift_x;
   assign shift_y = cfg.shift_y;
   assign row_s   = {1'b0, s1_row_ff};
   assign col_s   = {1'b0, s1_col_ff};

   assign prod_aj_in = rot_a * col_s;
   assign prod_bi_in = rot_b * row_s;
   assign prod_bj_in = rot_b * col_s;
   assign prod_ai_in = rot_a * row_s;

   assign local_ok = (32'(s1_row_ff) < 32'(LOCAL_SIZE)) && (32'(s1_col_ff) < 32'(LOCAL_SIZE));
   assign val_ok   = (s1_val_ff == ogf_pkg::VAL_OCCUPIED) || (s1_val_ff == ogf_pkg::VAL_FREE);

   // exact q.14 sums, arithmetic shift gives the floor
   assign x_sum   = SW'(prod_aj_ff) - SW'(prod_bi_ff) + SW'(shift_x);
   assign y_sum   = SW'(prod_bj_ff) + SW'(prod_ai_ff) + SW'(shift_y);
   assign gx_full = x_sum >>> ogf_pkg::FRAC_BITS;
   assign gy_full = y_sum >>> ogf_pkg::FRAC_BITS;

   assign in_grid = (gx_full > 0) && (gx_full < SW'(MAP_WIDTH)) &&
                    (gy_full > 0) && (gy_full < SW'(MAP_HEIGHT));

   assign push           = s2_valid_ff && !q_status.full;
   assign push_entry.upd = s2_ok_ff && in_grid;
   assign push_entry.hit = s2_hit_ff;
   assign push_entry.gx  = gx_full[ogf_pkg::COORD_W-1:0];
   assign push_entry.gy  = gy_full[ogf_pkg::COORD_W-1:0];

endmodule

// ===== design/ogf_back.sv =====
// back end: log-odds read-modify-write, saturation, classification, result register
module ogf_back #(
   parameter int MAP_WIDTH  = ogf_pkg::MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT = ogf_pkg::MAP_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ogf_pkg::cfg_type          cfg,
   input  ogf_pkg::queue_status_type q_status,
   input  ogf_pkg::entry_type        head,
   output logic                      pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ogf_pkg::rsp_type          rsp_payload
);

   localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = ogf_pkg::LO_W;
   localparam int GW    = ogf_pkg::GRID_FIELD_W;

   localparam logic B_IDLE = 1'b0;
   localparam logic B_UPD  = 1'b1;

   logic                 state_ff, state_in;
   logic                 hit_ff;
   logic [ogf_pkg::COORD_W-1:0] gx_ff, gy_ff;
   logic [AW-1:0]        addr_ff;
   logic                 clear_ff;
   logic [AW-1:0]        clear_addr_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   ogf_pkg::rsp_type     rsp_payload_ff, rsp_payload_in;

   logic                 out_free;
   logic                 issue;
   logic                 wr_upd;
   logic [AW-1:0]        addr_calc;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [LW-1:0]        ram_wr_data;
   logic [LW-1:0]        ram_rd_data;
   logic signed [LW-1:0] rd_s, incr;
   logic signed [LW:0]   sum_w, lim_w, sum_sat;
   logic signed [LW-1:0] lo_new;
   logic [1:0]           state_new;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign addr_calc = AW'(32'(head.gy) * 32'(MAP_WIDTH) + 32'(head.gx));

   // add the increment and clamp to the symmetric limit
   assign rd_s    = ram_rd_data;
   assign incr    = hit_ff ? cfg.hit_increment : cfg.miss_increment;
   assign sum_w   = (LW+1)'(rd_s) + (LW+1)'(incr);
   assign lim_w   = $signed({2'b00, cfg.log_odds_limit});

   always_comb begin
      if (sum_w < -lim_w) begin
         sum_sat = -lim_w;
      end else if (sum_w > lim_w) begin
         sum_sat = lim_w;
      end else begin
         sum_sat = sum_w;
      end
      lo_new = sum_sat[LW-1:0];
      if (sum_sat <= ogf_pkg::FREE_MAX) begin
         state_new = ogf_pkg::CELL_FREE;
      end else if (sum_sat >= ogf_pkg::OCC_MIN) begin
         state_new = ogf_pkg::CELL_OCCUPIED;
      end else begin
         state_new = ogf_pkg::CELL_UNKNOWN;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      pop            = 1'b0;
      issue          = 1'b0;
      wr_upd         = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!clear_ff && !q_status.empty) begin
               if (head.upd) begin
                  pop      = 1'b1;
                  issue    = 1'b1;
                  state_in = B_UPD;
               end else if (out_free) begin
                  // skipped cell: all-zero result, store untouched
                  pop            = 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_payload_in = '0;
               end
            end
         end
         B_UPD: begin
            if (out_free) begin
               wr_upd                      = 1'b1;
               rsp_valid_in                = 1'b1;
               rsp_payload_in.written      = 1'b1;
               rsp_payload_in.grid_x       = gx_ff[GW-1:0];
               rsp_payload_in.grid_y       = gy_ff[GW-1:0];
               rsp_payload_in.cell_state   = state_new;
               rsp_payload_in.log_odds_now = lo_new;
               state_in                    = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rsp_valid_ff  <= 1'b0;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear_ff) begin
            if (clear_addr_ff == AW'(DEPTH - 1)) begin
               clear_ff <= 1'b0;
            end
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (issue) begin
         hit_ff  <= head.hit;
         gx_ff   <= head.gx;
         gy_ff   <= head.gy;
         addr_ff <= addr_calc;
      end
   end

   // clearing pass owns the write port after reset
   assign ram_wr_en   = clear_ff || wr_upd;
   assign ram_wr_addr = clear_ff ? clear_addr_ff : addr_ff;
   assign ram_wr_data = clear_ff ? '0 : lo_new;

   ogf_ram #(
      .WIDTH (LW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (addr_calc),
      .rd_data (ram_rd_data)
   );

   assign clearing    = clear_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== sim/occupancy_grid_logodds_fusion_core_tb.sv =====
// testbench for the occupancy grid log-odds fusion core: random and directed cells, self-checking
`timescale 1ns / 1ps

module occupancy_grid_logodds_fusion_core_tb;
   import ogf_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_IDX = 3'd7;
   localparam int NUM_PHASES = 11;
   localparam int CELLS_PER_PHASE = 200;
   localparam int HOLD_CYCLES = 400;

   // keeps its own copy of the registers and the log-odds grid
   class logodds_scoreboard;
      cfg_type regs;
      logic signed [LO_W-1:0] lo_grid [int];
      rsp_type expected_cells [$];
      int mismatch_count;

      function new();
         regs.rot_a = ROT_A_RST;
         regs.rot_b = ROT_B_RST;
         regs.shift_x = SHIFT_RST;
         regs.shift_y = SHIFT_RST;
         regs.hit_increment = HIT_INC_RST;
         regs.miss_increment = MISS_INC_RST;
         regs.log_odds_limit = LIMIT_RST;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ROT_A: regs.rot_a = data[15:0];
            CSR_ROT_B: regs.rot_b = data[15:0];
            CSR_SHIFT_X: regs.shift_x = data[30:0];
            CSR_SHIFT_Y: regs.shift_y = data[30:0];
            CSR_HIT_INC: regs.hit_increment = data[15:0];
            CSR_MISS_INC: regs.miss_increment = data[15:0];
            CSR_LIMIT: regs.log_odds_limit = data[14:0];
            default: ;
         endcase
      endfunction

      function void predict_cell(req_type r);
         rsp_type e;
         longint row, col, ra, rb, sx, sy, px, py, sum, lim, inc;
         int key;
         e = '0;
         row = r.local_row;
         col = r.local_col;
         ra = regs.rot_a;
         rb = regs.rot_b;
         sx = regs.shift_x;
         sy = regs.shift_y;
         if (r.cell_value == VAL_OCCUPIED || r.cell_value == VAL_FREE) begin
            // arithmetic shift of the q.14 sum is the floor
            px = (ra * col - rb * row + sx) >>> FRAC_BITS;
            py = (rb * col + ra * row + sy) >>> FRAC_BITS;
            if (px > 0 && px < MAP_WIDTH_DEF && py > 0 && py < MAP_HEIGHT_DEF) begin
               key = int'(py * MAP_WIDTH_DEF + px);
               sum = lo_grid.exists(key) ? longint'(lo_grid[key]) : 64'sd0;
               inc = (r.cell_value == VAL_OCCUPIED) ? longint'(regs.hit_increment)
                                                    : longint'(regs.miss_increment);
               lim = longint'(regs.log_odds_limit);
               sum = sum + inc;
               if (sum < -lim) sum = -lim;
               else if (sum > lim) sum = lim;
               lo_grid[key] = sum[LO_W-1:0];
               e.written = 1'b1;
               e.grid_x = px[GRID_FIELD_W-1:0];
               e.grid_y = py[GRID_FIELD_W-1:0];
               if (sum <= FREE_MAX) e.cell_state = CELL_FREE;
               else if (sum >= OCC_MIN) e.cell_state = CELL_OCCUPIED;
               else e.cell_state = CELL_UNKNOWN;
               e.log_odds_now = sum[LO_W-1:0];
            end
         end
         expected_cells.push_back(e);
      endfunction

      function void check_cell(rsp_type got);
         rsp_type e;
         if (expected_cells.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: written=%0d x=%0d y=%0d state=%0d lo=%0d",
                        got.written, got.grid_x, got.grid_y, got.cell_state, got.log_odds_now);
         end else begin
            e = expected_cells.pop_front();
            if (got.written !== e.written || got.grid_x !== e.grid_x ||
                got.grid_y !== e.grid_y || got.cell_state !== e.cell_state ||
                got.log_odds_now !== e.log_odds_now) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: expected written=%0d x=%0d y=%0d state=%0d lo=%0d, got written=%0d x=%0d y=%0d state=%0d lo=%0d",
                           $realtime, e.written, e.grid_x, e.grid_y, e.cell_state,
                           e.log_odds_now, got.written, got.grid_x, got.grid_y,
                           got.cell_state, got.log_odds_now);
            end
         end
      endfunction

      function int pending();
         return expected_cells.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logodds_scoreboard book = new();
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int win_r;
   int win_c;

   occupancy_grid_logodds_fusion_core u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("occupancy_grid_logodds_fusion_core verification failed");
      $finish;
   end

   // receiver side: long hold-off when asked, random stalls otherwise
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_stall <= (int'($urandom_range(0, 99)) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_cell(rsp_payload);
   end

   function automatic req_type mk(int row, int col, logic [7:0] val);
      req_type r;
      r.local_row = 9'(row);
      r.local_col = 9'(col);
      r.cell_value = val;
      return r;
   endfunction

   // mostly hit/miss cells clustered on a window so cells get updated repeatedly
   function automatic req_type make_item();
      req_type r;
      r.local_row = 9'($urandom);
      r.local_col = 9'($urandom);
      r.cell_value = 8'($urandom);
      if ($urandom_range(0, 99) < 75) begin
         r.cell_value = ($urandom_range(0, 99) < 55) ? VAL_OCCUPIED : VAL_FREE;
         if ($urandom_range(0, 99) < 65) begin
            r.local_row = 9'(win_r + int'($urandom_range(0, 5)));
            r.local_col = 9'(win_c + int'($urandom_range(0, 5)));
         end
      end
      return r;
   endfunction

   task automatic send_req(input req_type r);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.predict_cell(r);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_phase(input int k);
      logic signed [15:0] ra16, rb16;
      longint ra, rb, sx, sy;
      if (k != 3) begin
         win_r = (k == 6) ? int'($urandom_range(0, 120)) : int'($urandom_range(0, 506));
         win_c = (k == 6) ? int'($urandom_range(0, 120)) : int'($urandom_range(0, 506));
      end
      case (k)
         1: begin
            write_csr(CSR_ROT_A, 31'(ROT_A_RST));
            write_csr(CSR_ROT_B, 31'(ROT_B_RST));
            write_csr(CSR_SHIFT_X, SHIFT_RST);
            write_csr(CSR_SHIFT_Y, SHIFT_RST);
            write_csr(CSR_HIT_INC, 31'(HIT_INC_RST));
            write_csr(CSR_MISS_INC, 31'(MISS_INC_RST));
            write_csr(CSR_LIMIT, 31'(LIMIT_RST));
            write_csr(CSR_UNUSED_IDX, 31'($urandom));
         end
         2: begin
            // mirrored map with the largest increments, saturates at once
            write_csr(CSR_ROT_A, 31'(-16'sd16384));
            write_csr(CSR_ROT_B, 31'd0);
            write_csr(CSR_SHIFT_X, 31'(511 * 16384 + int'($urandom_range(0, 16383))));
            write_csr(CSR_SHIFT_Y, 31'(511 * 16384 + int'($urandom_range(0, 16383))));
            write_csr(CSR_HIT_INC, 31'(16'sh7fff));
            write_csr(CSR_MISS_INC, 31'(16'sh8000));
            write_csr(CSR_LIMIT, 31'(15'h7fff));
         end
         3: begin
            // same cells, lowered limit clamps stored values on their next update
            write_csr(CSR_LIMIT, 31'd300);
            write_csr(CSR_HIT_INC, 31'd100);
            write_csr(CSR_MISS_INC, 31'(-16'sd100));
         end
         4: begin
            write_csr(CSR_LIMIT, 31'd0);
            write_csr(CSR_HIT_INC, 31'(16'($urandom)));
            write_csr(CSR_MISS_INC, 31'(16'($urandom)));
         end
         5: begin
            write_csr(CSR_ROT_A, 31'd0);
            write_csr(CSR_ROT_B, 31'd16384);
            write_csr(CSR_SHIFT_X, 31'(511 * 16384 + int'($urandom_range(0, 16383))));
            write_csr(CSR_SHIFT_Y, 31'($urandom_range(0, 16383)));
            write_csr(CSR_HIT_INC, 31'(HIT_INC_RST));
            write_csr(CSR_MISS_INC, 31'(MISS_INC_RST));
            write_csr(CSR_LIMIT, 31'(LIMIT_RST));
         end
         6: begin
            write_csr(CSR_ROT_A, 31'(16'sh7fff));
            write_csr(CSR_ROT_B, 31'(16'sh8000));
            write_csr(CSR_SHIFT_X, 31'd0);
            write_csr(CSR_SHIFT_Y, 31'(256 * 16384));
         end
         7: begin
            // shifts at their extremes push every cell off the grid
            write_csr(CSR_SHIFT_X, 31'h3fff_ffff);
            write_csr(CSR_SHIFT_Y, 31'h4000_0000);
         end
         default: begin
            ra16 = 16'($urandom);
            rb16 = 16'($urandom);
            ra = ra16;
            rb = rb16;
            // center the window on the middle of the grid
            sx = 256 * 16384 + longint'($urandom_range(0, 16383))
                 - (ra * (win_c + 2) - rb * (win_r + 2));
            sy = 256 * 16384 + longint'($urandom_range(0, 16383))
                 - (rb * (win_c + 2) + ra * (win_r + 2));
            write_csr(CSR_ROT_A, 31'(ra16));
            write_csr(CSR_ROT_B, 31'(rb16));
            write_csr(CSR_SHIFT_X, 31'(sx));
            write_csr(CSR_SHIFT_Y, 31'(sy));
            if (k == NUM_PHASES - 1) begin
               write_csr(CSR_HIT_INC, 31'(16'($urandom)));
               write_csr(CSR_MISS_INC, 31'(16'($urandom)));
            end else begin
               write_csr(CSR_HIT_INC, 31'($urandom_range(0, 1500)));
               write_csr(CSR_MISS_INC, 31'(-int'($urandom_range(0, 1500))));
            end
            write_csr(CSR_LIMIT, 31'($urandom_range(0, 32767)));
         end
      endcase
   endtask

   initial begin
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_cycles = 0;
      send_idle_pct = 17;
      recv_idle_pct = 70;
      win_r = 0;
      win_c = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < NUM_PHASES; k++) begin
         if (k < 4) begin
            send_idle_pct = 17;
            recv_idle_pct = 70;
         end else if (k < 7) begin
            send_idle_pct = 70;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (k > 0) begin
            drain();
            set_phase(k);
         end
         // receiver holds off while requests keep coming, so the core backs up
         if (k == 1 || k == 5) hold_cycles = HOLD_CYCLES;
         if (k == 0) begin
            send_req(mk(0, 0, VAL_OCCUPIED));
            send_req(mk(0, 9, VAL_OCCUPIED));
            send_req(mk(9, 0, VAL_FREE));
            send_req(mk(511, 511, VAL_OCCUPIED));
            send_req(mk(511, 511, VAL_FREE));
            send_req(mk(1, 1, VAL_FREE));
            send_req(mk(3, 4, 8'h80));
            send_req(mk(3, 4, 8'h7f));
            send_req(mk(3, 4, 8'd99));
            send_req(mk(3, 4, 8'd101));
            send_req(mk(3, 4, 8'd1));
            send_req(mk(3, 4, 8'hff));
            repeat (3) send_req(mk(5, 6, VAL_OCCUPIED));
            repeat (2) send_req(mk(6, 5, VAL_FREE));
            send_req(mk(300, 200, VAL_OCCUPIED));
            send_req(mk(200, 300, VAL_FREE));
            send_req(mk(256, 1, VAL_OCCUPIED));
            send_req(mk(1, 256, VAL_FREE));
            send_req(mk(511, 0, VAL_OCCUPIED));
            send_req(mk(0, 511, VAL_FREE));
         end else begin
            repeat ((k == 7) ? 50 : CELLS_PER_PHASE) send_req(make_item());
         end
      end
      drain();

      if (book.mismatch_count == 0 && book.pending() == 0)
         $display("occupancy_grid_logodds_fusion_core verification clean");
      else
         $display("occupancy_grid_logodds_fusion_core verification failed");
      $finish;
   end

endmodule
